/* hw/rtl/tlr_pkg.sv */
// Package for the thick line rasterizer.
// Field widths, register map and limits; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tlr_pkg;
  localparam int unsigned CoordW    = 16;
  localparam int unsigned ThickW    = 6;
  localparam int unsigned ColorW    = 24;
  localparam int unsigned InDataW   = 96;
  localparam int unsigned OutDataW  = 56;
  localparam int unsigned CfgAddrW  = 3;
  localparam logic [CfgAddrW-1:0] RegBrushMode = 3'd0;
  localparam logic ModeLoad = 1'b0;
  localparam logic ModeStep = 1'b1;
  localparam int unsigned MulAW = 34;
  localparam int unsigned MulBW = 27;
  localparam int unsigned MulPW = MulAW + MulBW;
  localparam int unsigned QuotW = 11;
endpackage
`default_nettype wire

/* hw/rtl/thick_line_rasterizer_core.sv */
// Thick line rasterizer top level.
// Depends on tlr_pkg.
// A load stalls the input while the first strand offsets are computed.
// Each step item of a loaded line yields one pixel, which shows in the cycle after
// it is taken; the step that ends a strand starts a new offset search, run on
// one shared 34x27 multiplier.
// Reset (rst_ni low, async) clears control state: no line loaded, brush_mode 0.
`timescale 1ns / 1ps
`default_nettype none
module thick_line_rasterizer_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // x_start, y_start, x_end, y_end, thickness, color, zero pad
  input  wire logic [tlr_pkg::InDataW-1:0]   s_axis_tdata_i,
  // mode
  input  wire logic                          s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // pixel_x, pixel_y, pixel_color
  output logic [tlr_pkg::OutDataW-1:0]       m_axis_tdata_o,
  output logic                               m_axis_tlast_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tlr_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import tlr_pkg::*;

  typedef enum logic [3:0] {
    S_RUN, S_L2X, S_L2Y, S_L2S, S_NM, S_AXA, S_AXSQ, S_LIM, S_BITSQ, S_BITL2, S_BITCMP
  } state_e;

  state_e state_q;
  logic brush_mode_q, brush_q, busy_q, axis_q;
  logic signed [CoordW-1:0] org_x_q, org_y_q, pos_x_q, pos_y_q, off_x_q, off_y_q;
  logic signed [CoordW:0] dx_q, dy_q;
  logic [CoordW-1:0] ax_q, ay_q, len_q, step_q;
  logic [CoordW:0] err_x_q, err_y_q;
  logic [ThickW-1:0] thick_q, row_q, col_q;
  logic [ColorW-1:0] color_q;
  logic signed [6:0] strand_q;
  logic [MulAW-1:0] l2_q;
  logic [10:0] n_q;
  logic [53:0] lim_q;
  logic [QuotW-1:0] quot_q;
  logic [3:0] bit_q;
  logic [MulPW-1:0] p_q;
  logic m_valid_q, m_last_q;
  logic [OutDataW-1:0] m_data_q;

  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [MulPW-1:0] mul_p;
  logic s_acc, cfg_wr, last_pix, strand_end, fit;
  logic [4:0] half, abs_i;
  logic [5:0] mfac;
  logic [QuotW-1:0] trial, quot_new;
  logic [11:0] cval;
  logic [CoordW-1:0] abs_d;
  logic signed [CoordW:0] dx_n, dy_n;
  logic signed [CoordW-1:0] xs, ys, xe, ye;
  logic [ThickW-1:0] t_in;
  logic [CoordW:0] ex_sum, ey_sum;
  logic [QuotW-1:0] quot_neg;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == RegBrushMode);
  assign prdata = (paddr == RegBrushMode) ? {31'd0, brush_mode_q} : 32'd0;

  assign s_axis_tready_o = (state_q == S_RUN) && (!m_valid_q || m_axis_tready_i);
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o = m_data_q;
  assign m_axis_tlast_o = m_last_q;

  assign xs = s_axis_tdata_i[15:0];
  assign ys = s_axis_tdata_i[31:16];
  assign xe = s_axis_tdata_i[47:32];
  assign ye = s_axis_tdata_i[63:48];
  assign t_in = s_axis_tdata_i[69:64];
  assign dx_n = 17'(signed'({xe[CoordW-1], xe}) - signed'({xs[CoordW-1], xs}));
  assign dy_n = 17'(signed'({ye[CoordW-1], ye}) - signed'({ys[CoordW-1], ys}));

  assign half = thick_q[ThickW-1:1];
  assign abs_i = strand_q[6] ? 5'(-strand_q) : strand_q[4:0];
  assign mfac = brush_q ? thick_q : 6'd1;
  assign abs_d = axis_q ? ax_q : ay_q;
  assign trial = quot_q | (11'd1 << bit_q);
  assign cval = brush_q ? {trial, 1'b0} : {1'b0, trial};
  assign fit = (p_q[57:0] <= {4'd0, lim_q}) && (l2_q != '0);
  assign quot_new = fit ? trial : quot_q;
  assign quot_neg = 11'(-quot_new);

  assign strand_end = step_q >= len_q;
  assign last_pix = (strand_q >= signed'({2'b00, half})) && strand_end &&
                    (!brush_q || ((7'(row_q) + 7'd1 == 7'(thick_q)) &&
                                  (7'(col_q) + 7'd1 == 7'(thick_q))));
  assign ex_sum = err_x_q + {1'b0, ax_q};
  assign ey_sum = err_y_q + {1'b0, ay_q};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_L2X: begin
        mul_a = 34'(ax_q);
        mul_b = 27'(ax_q);
      end
      S_L2Y: begin
        mul_a = 34'(ay_q);
        mul_b = 27'(ay_q);
      end
      S_L2S: begin
        mul_a = 34'(abs_i);
        mul_b = 27'(mfac);
      end
      S_AXA: begin
        mul_a = 34'(abs_d);
        mul_b = 27'(n_q);
      end
      S_AXSQ: begin
        mul_a = 34'(p_q[26:0]);
        mul_b = p_q[26:0];
      end
      S_BITSQ: begin
        mul_a = 34'(cval);
        mul_b = 27'(cval);
      end
      S_BITL2: begin
        mul_a = l2_q;
        mul_b = 27'(p_q[23:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = MulPW'(mul_a) * MulPW'(mul_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RUN;
      brush_mode_q <= 1'b0;
      busy_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        brush_mode_q <= pwdata[0];
      end
      if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      p_q <= mul_p;
      case (state_q)
        S_RUN: begin
          if (s_acc && s_axis_tuser_i == ModeLoad) begin
            org_x_q <= xs;
            org_y_q <= ys;
            pos_x_q <= xs;
            pos_y_q <= ys;
            dx_q <= dx_n;
            dy_q <= dy_n;
            ax_q <= dx_n[CoordW] ? 16'(-dx_n) : dx_n[CoordW-1:0];
            ay_q <= dy_n[CoordW] ? 16'(-dy_n) : dy_n[CoordW-1:0];
            len_q <= ((dx_n[CoordW] ? 16'(-dx_n) : dx_n[CoordW-1:0]) >
                      (dy_n[CoordW] ? 16'(-dy_n) : dy_n[CoordW-1:0])) ?
                     (dx_n[CoordW] ? 16'(-dx_n) : dx_n[CoordW-1:0]) :
                     (dy_n[CoordW] ? 16'(-dy_n) : dy_n[CoordW-1:0]);
            thick_q <= t_in;
            color_q <= s_axis_tdata_i[93:70];
            brush_q <= brush_mode_q;
            strand_q <= 7'(-signed'({2'b00, t_in[ThickW-1:1]}));
            busy_q <= !(brush_mode_q && t_in == '0);
            step_q <= '0;
            err_x_q <= '0;
            err_y_q <= '0;
            row_q <= '0;
            col_q <= '0;
            state_q <= S_L2X;
          end else if (s_acc && busy_q) begin
            m_valid_q <= 1'b1;
            m_last_q <= last_pix;
            m_data_q <= {color_q,
                         16'(pos_y_q + off_y_q + signed'({10'd0, row_q})),
                         16'(pos_x_q + off_x_q + signed'({10'd0, col_q}))};
            if (brush_q && (7'(col_q) + 7'd1 < 7'(thick_q))) begin
              col_q <= col_q + 6'd1;
            end else if (brush_q && (7'(row_q) + 7'd1 < 7'(thick_q))) begin
              col_q <= '0;
              row_q <= row_q + 6'd1;
            end else begin
              col_q <= '0;
              row_q <= '0;
              if (strand_end) begin
                if (strand_q >= signed'({2'b00, half})) begin
                  busy_q <= 1'b0;
                end else begin
                  strand_q <= strand_q + 7'sd1;
                  pos_x_q <= org_x_q;
                  pos_y_q <= org_y_q;
                  step_q <= '0;
                  err_x_q <= '0;
                  err_y_q <= '0;
                  state_q <= S_L2X;
                end
              end else begin
                step_q <= step_q + 16'd1;
                if (ex_sum >= {1'b0, len_q}) begin
                  err_x_q <= ex_sum - {1'b0, len_q};
                  pos_x_q <= dx_q > 0 ? pos_x_q + 16'sd1 : pos_x_q - 16'sd1;
                end else begin
                  err_x_q <= ex_sum;
                end
                if (ey_sum >= {1'b0, len_q}) begin
                  err_y_q <= ey_sum - {1'b0, len_q};
                  pos_y_q <= dy_q > 0 ? pos_y_q + 16'sd1 : pos_y_q - 16'sd1;
                end else begin
                  err_y_q <= ey_sum;
                end
              end
            end
          end
        end
        S_L2X: state_q <= S_L2Y;
        S_L2Y: begin
          l2_q <= p_q[MulAW-1:0];
          state_q <= S_L2S;
        end
        S_L2S: begin
          l2_q <= l2_q + p_q[MulAW-1:0];
          axis_q <= 1'b0;
          state_q <= S_NM;
        end
        S_NM: begin
          n_q <= p_q[10:0];
          state_q <= S_AXA;
        end
        S_AXA: state_q <= S_AXSQ;
        S_AXSQ: state_q <= S_LIM;
        S_LIM: begin
          lim_q <= p_q[53:0];
          quot_q <= '0;
          bit_q <= 4'd10;
          state_q <= S_BITSQ;
        end
        S_BITSQ: state_q <= S_BITL2;
        S_BITL2: state_q <= S_BITCMP;
        S_BITCMP: begin
          quot_q <= quot_new;
          if (bit_q == 4'd0) begin
            if (!axis_q) begin
              off_x_q <= ((dy_q < 0) == (strand_q < 0)) ?
                         16'(signed'(quot_neg)) : 16'(quot_new);
              axis_q <= 1'b1;
              state_q <= S_AXA;
            end else begin
              off_y_q <= ((dx_q < 0) != (strand_q < 0)) ?
                         16'(signed'(quot_neg)) : 16'(quot_new);
              state_q <= S_RUN;
            end
          end else begin
            bit_q <= bit_q - 4'd1;
            state_q <= S_BITSQ;
          end
        end
        default: state_q <= S_RUN;
      endcase
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/tlr_checker.sv */
// Port-level checks for the thick line rasterizer.
// Bound to thick_line_rasterizer_core; depends on tlr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tlr_port_checks (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         s_axis_tvalid_i,
  input wire logic                         s_axis_tready_o,
  input wire logic                         s_axis_tuser_i,
  input wire logic                         m_axis_tvalid_o,
  input wire logic                         m_axis_tready_i,
  input wire logic [tlr_pkg::OutDataW-1:0] m_axis_tdata_o,
  input wire logic                         pready
);
  import tlr_pkg::*;

  a_load_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == ModeLoad |=> !s_axis_tready_o)
    else $error("ready after load");

  a_load_no_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == ModeLoad && !m_axis_tvalid_o
    |=> !m_axis_tvalid_o)
    else $error("load produced item");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output item dropped");
endmodule

bind thick_line_rasterizer_core tlr_port_checks u_tlr_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o), .s_axis_tuser_i(s_axis_tuser_i),
  .m_axis_tvalid_o(m_axis_tvalid_o), .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o(m_axis_tdata_o), .pready(pready)
);
`default_nettype wire

/* bench/tlr_checker.sv */
// Checker for the thick line rasterizer: watches both streams and the APB port,
// predicts every pixel and compares it. Depends on tlr_pkg.
`timescale 1ns / 1ps
module tlr_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [tlr_pkg::InDataW-1:0]   s_tdata,
  input  logic                          s_tuser,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [tlr_pkg::OutDataW-1:0]  m_tdata,
  input  logic                          m_tlast,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tlr_pkg::CfgAddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output int                            errors,
  output int                            pending
);
  import tlr_pkg::*;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [23:0] color;
    logic        last;
  } pixel_t;

  pixel_t expected_pixels[$];
  logic cfg_brush;
  logic line_busy, line_brush;
  longint org_x, org_y, dlt_x, dlt_y, abs_x, abs_y, walk_len;
  longint thick, strand, off_x, off_y, pos_x, pos_y, err_x, err_y, steps, row, col;
  logic [23:0] line_color;

  assign pending = expected_pixels.size();

  function automatic longint offset_quot(longint a, longint l2, longint k);
    longint q, c;
    q = 0;
    if (l2 == 0) return 0;
    for (int b = 10; b >= 0; b--) begin
      c = (q | (64'sd1 << b)) * k;
      if (c * c * l2 <= a * a) q = q | (64'sd1 << b);
    end
    return q;
  endfunction

  task automatic begin_strand();
    longint l2, m, k, nx, ny, qx, qy;
    l2 = abs_x * abs_x + abs_y * abs_y;
    m = line_brush ? thick : 1;
    k = line_brush ? 2 : 1;
    nx = dlt_y * strand * m;
    ny = dlt_x * strand * m;
    qx = offset_quot(nx < 0 ? -nx : nx, l2, k);
    qy = offset_quot(ny < 0 ? -ny : ny, l2, k);
    off_x = nx > 0 ? -qx : qx;
    off_y = ny < 0 ? -qy : qy;
    pos_x = org_x; pos_y = org_y;
    err_x = 0; err_y = 0; steps = 0; row = 0; col = 0;
  endtask

  task automatic walk_next();
    if (steps >= walk_len) begin
      if (strand >= thick / 2) line_busy = 0;
      else begin
        strand++;
        begin_strand();
      end
      return;
    end
    steps++;
    err_x += abs_x;
    err_y += abs_y;
    if (err_x >= walk_len) begin
      err_x -= walk_len;
      pos_x += dlt_x > 0 ? 1 : -1;
    end
    if (err_y >= walk_len) begin
      err_y -= walk_len;
      pos_y += dlt_y > 0 ? 1 : -1;
    end
  endtask

  task automatic predict_item(logic [InDataW-1:0] d, logic mode);
    pixel_t p;
    longint px, py;
    if (mode == ModeLoad) begin
      org_x = longint'($signed(d[15:0]));
      org_y = longint'($signed(d[31:16]));
      dlt_x = longint'($signed(d[47:32])) - org_x;
      dlt_y = longint'($signed(d[63:48])) - org_y;
      abs_x = dlt_x < 0 ? -dlt_x : dlt_x;
      abs_y = dlt_y < 0 ? -dlt_y : dlt_y;
      walk_len = abs_x > abs_y ? abs_x : abs_y;
      thick = longint'(d[69:64]);
      line_color = d[93:70];
      line_brush = cfg_brush;
      strand = -(thick / 2);
      begin_strand();
      line_busy = !(line_brush && thick == 0);
      return;
    end
    if (!line_busy) return;
    p.last = strand >= thick / 2 && steps >= walk_len;
    if (line_brush) p.last = p.last && row + 1 == thick && col + 1 == thick;
    px = pos_x + off_x + col;
    py = pos_y + off_y + row;
    p.x = px[15:0];
    p.y = py[15:0];
    p.color = line_color;
    expected_pixels.push_back(p);
    if (line_brush) begin
      col++;
      if (col >= thick) begin
        col = 0;
        row++;
        if (row >= thick) begin
          row = 0;
          walk_next();
        end
      end
    end else walk_next();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t got, want;
    if (!rst_ni) begin
      errors <= 0;
      cfg_brush = 0;
      line_busy = 0;
      expected_pixels.delete();
    end else begin
      if (psel && penable && pwrite && paddr == RegBrushMode) cfg_brush = pwdata[0];
      if (m_tvalid && m_tready) begin
        got = {m_tdata[15:0], m_tdata[31:16], m_tdata[55:32], m_tlast};
        if (expected_pixels.size() == 0) begin
          if (errors < 10) $display("unexpected pixel %h", got);
          errors <= errors + 1;
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            if (errors < 10) $display("pixel mismatch: expected %h got %h", want, got);
            errors <= errors + 1;
          end
        end
      end
      if (s_tvalid && s_tready) predict_item(s_tdata, s_tuser);
    end
  end
endmodule

/* bench/testbench.sv */
// Top of the rasterizer bench: clock, reset, APB writes, stream stimulus
// and the verdict. Depends on tlr_pkg, thick_line_rasterizer_core and tlr_checker.
`timescale 1ns / 1ps
module testbench;
  import tlr_pkg::*;

  logic clk = 0, rst_n = 0;
  logic s_tvalid = 0, s_tready, s_tuser = 0;
  logic [InDataW-1:0] s_tdata = '0;
  logic m_tvalid, m_tready = 0, m_tlast;
  logic [OutDataW-1:0] m_tdata;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  int errors, pending, idle_cycles = 0;
  logic hold_off = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  thick_line_rasterizer_core u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tlast_o(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tlr_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .errors(errors), .pending(pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n || hold_off) m_tready <= 0;
    else m_tready <= (gap_len() == 0);
  end

  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 20000) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic apb_write(logic [CfgAddrW-1:0] a, logic [31:0] v);
    @(posedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= a; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic send(logic mode, logic [15:0] xs, logic [15:0] ys, logic [15:0] xe,
                      logic [15:0] ye, logic [5:0] th, logic [23:0] col);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= mode;
    s_tdata <= {2'b00, col, th, ye, xe, ys, xs};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic rand_line(int span, int tmax);
    logic [15:0] x0, y0;
    x0 = 16'($urandom);
    y0 = 16'($urandom);
    send(ModeLoad, x0, y0, x0 + 16'($urandom_range(0, 2 * span) - span),
         y0 + 16'($urandom_range(0, 2 * span) - span),
         6'($urandom_range(0, tmax)), 24'($urandom));
  endtask

  task automatic steps(int n);
    repeat (n) send(ModeStep, 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 6'($urandom), 24'($urandom));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1;
    // directed: idle step, extremes, zero length, zero thickness
    steps(1);
    send(ModeLoad, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 6'd0, 24'hFFFFFF);
    steps(2);
    send(ModeLoad, 16'h7FFE, 16'h0000, 16'h8001, 16'h0003, 6'd3, 24'h000000);
    steps(6);
    send(ModeLoad, 16'h0000, 16'h0000, 16'h0002, 16'hFFFF, 6'd63, 24'hA5A55A);
    steps(3);
    send(ModeLoad, 16'h0010, 16'h0010, 16'h0013, 16'h0012, 6'd2, 24'h123456);
    steps(9);
    drain();
    apb_write(RegBrushMode, 32'd1);
    send(ModeLoad, 16'h0000, 16'h0000, 16'h0004, 16'h0004, 6'd0, 24'h111111);
    steps(1);
    send(ModeLoad, 16'hFFFE, 16'h0001, 16'h0000, 16'hFFFF, 6'd2, 24'h222222);
    steps(14);
    drain();
    // hold off the receiver while items keep coming
    hold_off = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      begin
        send(ModeLoad, 16'h0100, 16'h0100, 16'h0103, 16'h0101, 6'd3, 24'h333333);
        steps(40);
      end
    join
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      apb_write(RegBrushMode, 32'(ph % 2));
      repeat (18) begin
        rand_line(($urandom_range(0, 9) == 0) ? 32767 : 6, (ph % 2) ? 4 : 63);
        steps($urandom_range(3, 15));
      end
      drain();
    end
    apb_write(RegBrushMode, 32'd0);
    drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

/* thick_line_rasterizer_core.f */
hw/rtl/tlr_pkg.sv
hw/rtl/thick_line_rasterizer_core.sv
hw/rtl/tlr_checker.sv
bench/tlr_checker.sv
bench/testbench.sv
